FILE: rtl/pgc_pkg.sv
// Shared widths, latency and the constant log-distance table for the gamma pipeline.
package pgc_pkg;

   localparam int GAMMA_FRAC_BITS = 12;
   localparam int PIX_W           = 8;
   localparam int INV_W           = 16;
   localparam int LOG_FRAC        = 24;
   localparam int LOG_W           = LOG_FRAC + 3;
   localparam int MANT_FRAC       = 30;
   localparam int CMP_W           = LOG_W + ((GAMMA_FRAC_BITS > INV_W) ? GAMMA_FRAC_BITS : INV_W);
   localparam int PIX_N           = 1 << PIX_W;
   localparam int SRCH_STAGES     = PIX_W;
   // lookup stage, multiply stage, one stage per result bit
   localparam int PIPE_DEPTH      = 2 + SRCH_STAGES;
   localparam logic [INV_W-1:0] INV_GAMMA_RESET = INV_W'(1 << GAMMA_FRAC_BITS);

   typedef logic [LOG_W-1:0] dist_table_type [PIX_N];

   // D(v) = log2(255) - log2(v) in Q3.24; log2 fraction by repeated squaring
   function automatic dist_table_type build_dist_table();
      dist_table_type  tab;
      logic [63:0]     lgs [PIX_N];
      logic [63:0]     m;
      logic [63:0]     n;
      logic [63:0]     frac;
      int              v;
      int              b;
      int              k;
      for (v = 0; v < PIX_N; v++) begin
         lgs[v] = 64'd0;
         if (v != 0) begin
            n = 64'd0;
            for (b = 1; b < PIX_W; b++) begin
               if ((v >> b) != 0) begin
                  n = 64'(b);
               end
            end
            m    = 64'(v) << (MANT_FRAC - int'(n));
            frac = 64'd0;
            for (k = 0; k < LOG_FRAC; k++) begin
               m    = (m * m) >> MANT_FRAC;
               frac = frac << 1;
               if (m >= (64'd2 << MANT_FRAC)) begin
                  frac = frac | 64'd1;
                  m    = m >> 1;
               end
            end
            lgs[v] = (n << LOG_FRAC) | frac;
         end
      end
      for (v = 0; v < PIX_N; v++) begin
         tab[v] = (v == 0) ? '0 : LOG_W'(lgs[PIX_N-1] - lgs[v]);
      end
      return tab;
   endfunction

   localparam dist_table_type DIST_TABLE = build_dist_table();

endpackage

FILE: rtl/pixel_gamma_correction_top.sv
// Pixel gamma correction: log-distance lookup, exponent multiply, bitwise search pipeline.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------------------
//  request  | req_pixel_in, req_frame_end_in               | start & !busy
//  response | rsp_pixel_out, rsp_frame_end_out             | rsp_valid, one-cycle strobe
//  csr      | csr_inv_gamma                                | csr_valid & csr_ready
//
// One pixel enters per clock; its result passes through PIPE_DEPTH stages: one stage for
// the log-distance lookup, one for the 16 x 27 exponent multiply, one per output bit of the
// search. Busy is high only during reset; synchronous reset clears all valid bits and loads
// inv_gamma with 1.0. The receiver cannot stall, so the pipeline never holds.
module pixel_gamma_correction_top
   import pgc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [PIX_W-1:0] req_pixel_in,
   input  logic             req_frame_end_in,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_frame_end_out,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [INV_W-1:0] csr_inv_gamma
);

   logic [INV_W-1:0] inv_gamma_ff;

   logic             lk_valid_ff, lk_valid_in;
   logic [LOG_W-1:0] lk_dist_ff;
   logic             lk_zero_ff;
   logic             lk_fe_ff;

   logic             srch_valid_ff [SRCH_STAGES+1];
   logic [CMP_W-1:0] srch_target_ff [SRCH_STAGES+1];
   logic [PIX_W-1:0] srch_y_ff [SRCH_STAGES+1];
   logic             srch_fe_ff [SRCH_STAGES+1];

   logic [CMP_W-1:0] prod_in;

   assign busy        = reset;
   assign csr_ready   = 1'b1;
   assign lk_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_gamma_ff <= INV_GAMMA_RESET;
      end else if (csr_valid && csr_ready) begin
         inv_gamma_ff <= csr_inv_gamma;
      end
   end

   // lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
      end else begin
         lk_valid_ff <= lk_valid_in;
      end
      lk_dist_ff <= DIST_TABLE[req_pixel_in];
      lk_zero_ff <= (req_pixel_in == '0);
      lk_fe_ff   <= req_frame_end_in;
   end

   // multiply stage; black forces a target no trial value can reach
   assign prod_in = CMP_W'(inv_gamma_ff) * CMP_W'(lk_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_valid_ff[0] <= 1'b0;
      end else begin
         srch_valid_ff[0] <= lk_valid_ff;
      end
      srch_target_ff[0] <= lk_zero_ff ? '1 : prod_in;
      srch_y_ff[0]      <= '0;
      srch_fe_ff[0]     <= lk_fe_ff;
   end

   // one result bit per stage, top bit first
   for (genvar k = 0; k < SRCH_STAGES; k++) begin : g_srch
      logic [PIX_W-1:0] trial;
      logic [CMP_W-1:0] scaled;
      logic [PIX_W-1:0] y_in;

      assign trial  = srch_y_ff[k] | (PIX_W'(1) << (PIX_W - 1 - k));
      assign scaled = CMP_W'(DIST_TABLE[trial]) << GAMMA_FRAC_BITS;
      assign y_in   = (scaled >= srch_target_ff[k]) ? trial : srch_y_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_valid_ff[k+1] <= 1'b0;
         end else begin
            srch_valid_ff[k+1] <= srch_valid_ff[k];
         end
         srch_target_ff[k+1] <= srch_target_ff[k];
         srch_y_ff[k+1]      <= y_in;
         srch_fe_ff[k+1]     <= srch_fe_ff[k];
      end
   end

   assign rsp_valid         = srch_valid_ff[SRCH_STAGES];
   assign rsp_pixel_out     = srch_y_ff[SRCH_STAGES];
   assign rsp_frame_end_out = srch_fe_ff[SRCH_STAGES];

endmodule

FILE: rtl/pgc_checker.sv
// Port-level checks for the gamma pipeline, bound to the top level.
module pgc_checker
   import pgc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [PIX_W-1:0] req_pixel_in,
   input logic             req_frame_end_in,
   input logic             rsp_valid,
   input logic [PIX_W-1:0] rsp_pixel_out,
   input logic             rsp_frame_end_out
);

   // every accepted transfer yields a result a fixed latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted pixel produced no result");

   // no result without a matching transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without accepted pixel");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH
         (rsp_frame_end_out == $past(req_frame_end_in, PIPE_DEPTH)))
      else $error("frame end flag not carried through");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_pixel_in == '0) |-> ##PIPE_DEPTH (rsp_pixel_out == '0))
      else $error("black pixel not mapped to black");

   a_white: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_pixel_in == '1) |-> ##PIPE_DEPTH (rsp_pixel_out == '1))
      else $error("white pixel not mapped to white");

endmodule

bind pixel_gamma_correction_top pgc_checker u_pgc_checker (.*);

FILE: verif/tb_pixel_gamma_correction_top.sv
// Self-checking bench for the pixel gamma pipeline: directed probes, then random bursts.
`timescale 1ns / 100ps

module tb_pixel_gamma_correction_top
   import pgc_pkg::*;
();

   localparam logic [INV_W-1:0] UNITY_GAMMA = 16'h1000;
   localparam int EXP_FRAC     = 12;
   localparam int LOG_FRAC_B   = 24;
   localparam int MANT_FRAC_B  = 30;
   localparam int DRAIN_CYCLES = 16;   // pipeline is ten deep
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PROBE_N      = 22;
   localparam int PHASE_N      = 6;
   localparam int PHASE_ITEMS  = 75;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic             frame_end;
   } graded_pixel_type;

   typedef struct packed {
      logic [INV_W-1:0] inv_gamma;
      logic [PIX_W-1:0] level;
      logic             frame_end;
      logic             known;
      logic [PIX_W-1:0] known_level;
   } probe_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [PIX_W-1:0] req_pixel_in;
   logic             req_frame_end_in;
   logic             rsp_valid;
   logic [PIX_W-1:0] rsp_pixel_out;
   logic             rsp_frame_end_out;
   logic             csr_valid;
   logic             csr_ready;
   logic [INV_W-1:0] csr_inv_gamma;

   logic [63:0]      log_q24 [256];
   logic [INV_W-1:0] gamma_now;
   graded_pixel_type pending_levels [$];
   probe_type        probes [PROBE_N];
   int               error_count;
   int               cycle_count;

   pixel_gamma_correction_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pixel_in      (req_pixel_in),
      .req_frame_end_in  (req_frame_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_frame_end_out (rsp_frame_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_inv_gamma     (csr_inv_gamma)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // log2(v) in Q3.24, fraction by repeated squaring of a Q1.30 mantissa
   function automatic logic [63:0] log2_fixed(input int v);
      logic [63:0] m;
      logic [63:0] frac;
      int          msb;
      int          k;
      if (v == 0) return 64'd0;
      msb = 0;
      while (msb < 7 && (v >> (msb + 1)) != 0) msb++;
      m    = 64'(v) << (MANT_FRAC_B - msb);
      frac = 64'd0;
      for (k = 0; k < LOG_FRAC_B; k++) begin
         m    = (m * m) >> MANT_FRAC_B;
         frac = frac << 1;
         if (m >= (64'd2 << MANT_FRAC_B)) begin
            frac = frac | 64'd1;
            m    = m >> 1;
         end
      end
      return (64'(msb) << LOG_FRAC_B) | frac;
   endfunction

   // largest y whose log distance from white covers the scaled distance of p
   function automatic logic [PIX_W-1:0] corrected_level(input logic [PIX_W-1:0] p,
                                                        input logic [INV_W-1:0] ig);
      logic [63:0]      top;
      logic [63:0]      target;
      logic [63:0]      dy;
      logic [PIX_W-1:0] y;
      logic [PIX_W-1:0] t;
      int               b;
      if (p == '0) return '0;
      top    = log_q24[255];
      target = 64'(ig) * (top - log_q24[p]);
      y      = '0;
      for (b = PIX_W - 1; b >= 0; b--) begin
         t  = y | (PIX_W'(1) << b);
         dy = top - log_q24[t];
         if ((dy << EXP_FRAC) >= target) y = t;
      end
      return y;
   endfunction

   task automatic report_mismatch(input string what, input int expv, input int gotv);
      $display("ERROR t=%0t %s: expected %0d, got %0d", $realtime, what, expv, gotv);
      error_count++;
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] level, input logic fe,
                             input logic known, input logic [PIX_W-1:0] known_level);
      graded_pixel_type e;
      @(negedge clock);
      start            <= 1'b1;
      req_pixel_in     <= level;
      req_frame_end_in <= fe;
      @(posedge clock);
      while (busy) @(posedge clock);
      e.level     = known ? known_level : corrected_level(level, gamma_now);
      e.frame_end = fe;
      pending_levels.push_back(e);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop sending and wait until every transfer has come back
   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_inv_gamma(input logic [INV_W-1:0] val);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_inv_gamma <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gamma_now = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] random_level();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return PIX_W'($urandom_range(1, 3));
         3:       return PIX_W'($urandom_range(252, 254));
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   always @(posedge clock) begin
      graded_pixel_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pixel_gamma_correction_top: mismatch");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            report_mismatch("unexpected result, pixel", 0, rsp_pixel_out);
         end else begin
            e = pending_levels.pop_front();
            if (rsp_pixel_out !== e.level)
               report_mismatch("pixel_out", e.level, rsp_pixel_out);
            if (rsp_frame_end_out !== e.frame_end)
               report_mismatch("frame_end_out", e.frame_end, rsp_frame_end_out);
         end
      end
   end

   initial begin
      int               v;
      int               i;
      int               ph;
      int               sent;
      int               burst;
      logic [INV_W-1:0] setting;

      error_count      = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_pixel_in     = '0;
      req_frame_end_in = 1'b0;
      csr_valid        = 1'b0;
      csr_inv_gamma    = '0;
      gamma_now        = UNITY_GAMMA;
      for (v = 0; v < 256; v++) log_q24[v] = log2_fixed(v);

      // inv_gamma, pixel, frame end, known, known pixel
      probes = '{
         {16'h1000, 8'd0,   1'b0, 1'b1, 8'd0},    // unity exponent straight from reset
         {16'h1000, 8'd255, 1'b1, 1'b1, 8'd255},
         {16'h1000, 8'd1,   1'b0, 1'b1, 8'd1},
         {16'h1000, 8'd128, 1'b1, 1'b1, 8'd128},
         {16'h1000, 8'd85,  1'b0, 1'b1, 8'd85},
         {16'h0000, 8'd0,   1'b1, 1'b1, 8'd0},    // zero exponent: black stays black
         {16'h0000, 8'd1,   1'b0, 1'b1, 8'd255},
         {16'h0000, 8'd200, 1'b1, 1'b1, 8'd255},
         {16'hFFFF, 8'd255, 1'b0, 1'b1, 8'd255},
         {16'hFFFF, 8'd0,   1'b0, 1'b1, 8'd0},
         {16'hFFFF, 8'd1,   1'b1, 1'b1, 8'd0},    // saturates to black
         {16'hFFFF, 8'd254, 1'b0, 1'b0, 8'd0},
         {16'h0001, 8'd1,   1'b0, 1'b0, 8'd0},
         {16'h0001, 8'd255, 1'b1, 1'b1, 8'd255},
         {16'h0001, 8'd0,   1'b0, 1'b1, 8'd0},
         {16'h0001, 8'd127, 1'b0, 1'b0, 8'd0},
         {16'h0800, 8'd64,  1'b1, 1'b0, 8'd0},
         {16'h0800, 8'd170, 1'b0, 1'b0, 8'd0},
         {16'h0800, 8'd2,   1'b0, 1'b0, 8'd0},
         {16'h2000, 8'd16,  1'b0, 1'b0, 8'd0},
         {16'h2000, 8'd240, 1'b1, 1'b0, 8'd0},
         {16'h2000, 8'd255, 1'b0, 1'b1, 8'd255}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < PROBE_N; i++) begin
         if (probes[i].inv_gamma != gamma_now) begin
            drain();
            write_inv_gamma(probes[i].inv_gamma);
         end
         push_pixel(probes[i].level, probes[i].frame_end, probes[i].known,
                    probes[i].known_level);
      end

      for (ph = 0; ph < PHASE_N; ph++) begin
         case (ph)
            0:       setting = 16'hFFFF;
            1:       setting = 16'h0001;
            2:       setting = INV_W'($urandom_range(1024, 16384));
            3:       setting = UNITY_GAMMA;
            default: setting = INV_W'($urandom_range(1, 65535));
         endcase
         drain();
         write_inv_gamma(setting);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // phase 3 sends all its pixels in one back-to-back burst; other phases use random bursts
            burst = (ph == 3) ? PHASE_ITEMS : $urandom_range(1, 24);
            for (i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
               push_pixel(random_level(), ($urandom_range(0, 3) == 0), 1'b0, '0);
               sent++;
            end
            if ($urandom_range(0, 4) == 0) hold_off($urandom_range(8, 14));
            else                          hold_off($urandom_range(0, 5));
         end
      end

      drain();
      if (pending_levels.size() != 0)
         report_mismatch("results never returned", 0, pending_levels.size());
      if (error_count == 0) begin
         $display("pixel_gamma_correction_top: match");
      end else begin
         $display("pixel_gamma_correction_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: pixel_gamma_correction_top.f
rtl/pgc_pkg.sv
rtl/pixel_gamma_correction_top.sv
rtl/pgc_checker.sv
verif/tb_pixel_gamma_correction_top.sv
